FILE: design/rgbu_pkg.sv
// ----------------------------------------------------------------------------
// rgbu_pkg
// shared types and constants of the rotated glyph bit unpacker
// ----------------------------------------------------------------------------
package rgbu_pkg;

  localparam int unsigned MAX_RESULTS = 56;
  localparam int unsigned MAX_COLUMNS = 16;
  localparam logic [7:0]  FULL_MASK   = 8'hFF;
  localparam logic [3:0]  PAGE_BITS   = 4'd8;

  // register indexes on the configuration port (byte address 4*index)
  localparam logic [1:0] REG_Y_OFFSET = 2'd0;
  localparam logic [1:0] REG_ROWS     = 2'd1;
  localparam logic [1:0] REG_COLUMNS  = 2'd2;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       first_of_glyph;
  } in_t;

  typedef struct packed {
    logic [7:0] page_byte;
    logic       last_of_run;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH
  } st_t;

endpackage

FILE: design/rotated_glyph_bit_unpacker.sv
// ----------------------------------------------------------------------------
// rotated_glyph_bit_unpacker
// cuts packed lsb-first glyph bits into column page bytes for a display
// ----------------------------------------------------------------------------
// Each accepted input byte is walked by one shared page step unit under a
// small sequencer, one step per clock: a step either produces one page byte
// or ends the walk for this byte. The walk of an input byte that yields page
// bytes runs through acceptance, one producing step per page byte, a closing
// step and a flush step that hands over the last page byte with last_of_run
// set; a byte that yields no page byte has only acceptance and the closing
// step. When the walk stops at the limit of 56 page bytes there is no closing
// step. The block takes the next byte only once the walk is over.
// The step unit only advances while the result register is free, so a
// stalled output simply stretches the walk.
// in_stall is high from acceptance until the last page byte is in the result
// register. Configuration registers must be written only while idle.
module rotated_glyph_bit_unpacker (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  rgbu_pkg::in_t      in_data,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output rgbu_pkg::out_t     out_data,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  import rgbu_pkg::*;

  // configuration registers
  logic [4:0] cfg_y_r;
  logic [5:0] cfg_rows_r;
  logic [4:0] cfg_cols_r;

  // unpack state
  logic [7:0] hb_r,   hb_nxt;    // held bits
  logic [3:0] hbc_r,  hbc_nxt;   // held bit count
  logic [6:0] rsb_r,  rsb_nxt;   // row start bit
  logic [4:0] cl_r,   cl_nxt;    // columns left
  logic [6:0] cbp_r,  cbp_nxt;   // column bit position
  logic [7:0] po_r,   po_nxt;    // partial out
  logic [3:0] poc_r,  poc_nxt;   // partial out count

  // sequencer
  st_t        state_r, state_nxt;
  logic [5:0] n_r, n_nxt;
  logic       pend_valid_r, pend_valid_nxt;
  logic [7:0] pend_val_r, pend_val_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_t       out_data_r, out_data_nxt;

  logic       in_accept;
  logic       out_free;
  logic       cfg_write;

  // page step unit
  logic [4:0] eff_cols;
  logic [6:0] per_col;
  logic [6:0] gap;
  logic [3:0] need_out;
  logic [7:0] need_col;
  logic [7:0] merged;
  logic [3:0] filled;
  logic       take_partial;
  logic       page_done;
  logic       it_emit;
  logic       it_break;
  logic [7:0] it_val;
  logic [7:0] it_hb;
  logic [3:0] it_hbc;
  logic [6:0] it_rsb;
  logic [4:0] it_cl;
  logic [6:0] it_cbp;
  logic [7:0] it_po;
  logic [3:0] it_poc;

  // --------------------------------------------------------------------------
  // configuration port
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_y_r    <= 5'd0;
      cfg_rows_r <= 6'd8;
      cfg_cols_r <= 5'd8;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_Y_OFFSET: cfg_y_r    <= pwdata[4:0];
        REG_ROWS:     cfg_rows_r <= pwdata[5:0];
        REG_COLUMNS:  cfg_cols_r <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = 32'd0;
    unique case (paddr[3:2])
      REG_Y_OFFSET: prdata = {27'd0, cfg_y_r};
      REG_ROWS:     prdata = {26'd0, cfg_rows_r};
      REG_COLUMNS:  prdata = {27'd0, cfg_cols_r};
      default:      prdata = 32'd0;
    endcase
  end

  // column count: zero acts as one, anything above the maximum saturates
  always_comb begin
    if (cfg_cols_r == 5'd0) begin
      eff_cols = 5'd1;
    end else if (cfg_cols_r > 5'(MAX_COLUMNS)) begin
      eff_cols = 5'(MAX_COLUMNS);
    end else begin
      eff_cols = cfg_cols_r;
    end
  end

  // bit position where the bitmap of a column ends
  assign per_col = {2'b00, cfg_y_r} + {1'b0, cfg_rows_r};

  // --------------------------------------------------------------------------
  // page step unit: one pass of the unpack walk from the current state
  // --------------------------------------------------------------------------
  always_comb begin
    it_hb        = hb_r;
    it_hbc       = hbc_r;
    it_rsb       = rsb_r;
    it_cl        = (cl_r == 5'd0) ? eff_cols : cl_r;
    it_cbp       = cbp_r;
    it_po        = po_r;
    it_poc       = poc_r;
    it_emit      = 1'b0;
    it_break     = 1'b0;
    it_val       = 8'd0;
    take_partial = 1'b0;
    page_done    = 1'b0;
    gap          = {2'b00, cfg_y_r} - cbp_r;
    need_out     = 4'd0;
    need_col     = 8'd0;
    merged       = 8'd0;
    filled       = 4'd0;

    // blank rows above the bitmap: a whole blank page or a blank head
    if (poc_r == 4'd0 && cbp_r < {2'b00, cfg_y_r}) begin
      if (gap >= 7'd8) begin
        it_emit   = 1'b1;
        it_val    = 8'd0;
        page_done = 1'b1;
      end else begin
        it_poc = gap[3:0];
        it_po  = 8'd0;
        it_cbp = {2'b00, cfg_y_r};
      end
    end

    if (!it_emit) begin
      if (it_hbc == 4'd0) begin
        it_break = 1'b1;
      end else begin
        need_out = PAGE_BITS - it_poc;
        need_col = {1'b0, per_col} - {1'b0, it_cbp};
        merged   = it_po | (it_hb << it_poc);
        if ({4'd0, need_out} > need_col) begin
          // last page of the column, masked to the bits that remain
          if ({4'd0, it_hbc} >= need_col) begin
            filled    = it_poc + need_col[3:0];
            it_emit   = 1'b1;
            it_val    = merged & (FULL_MASK >> (PAGE_BITS - filled));
            it_hb     = it_hb >> need_col[3:0];
            it_hbc    = it_hbc - need_col[3:0];
            page_done = 1'b1;
          end else begin
            take_partial = 1'b1;
          end
        end else if (it_hbc >= need_out) begin
          it_emit   = 1'b1;
          it_val    = merged;
          it_hb     = it_hb >> need_out;
          it_hbc    = it_hbc - need_out;
          page_done = 1'b1;
        end else begin
          take_partial = 1'b1;
        end
      end
    end

    // not enough bits for a page: keep the partial page and wait for data
    if (take_partial) begin
      it_cbp   = it_cbp + {3'd0, it_hbc};
      it_poc   = it_poc + it_hbc;
      it_po    = merged;
      it_hb    = 8'd0;
      it_hbc   = 4'd0;
      it_break = 1'b1;
    end

    // advance to the next column, or to the next row of pages
    if (page_done) begin
      if (it_cl > 5'd1) begin
        it_cl = it_cl - 5'd1;
      end else begin
        it_cl  = eff_cols;
        it_rsb = it_rsb + 7'd8;
      end
      it_cbp = it_rsb;
      it_po  = 8'd0;
      it_poc = 4'd0;
    end
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      hb_r         <= 8'd0;
      hbc_r        <= 4'd0;
      rsb_r        <= 7'd0;
      cl_r         <= 5'd0;
      cbp_r        <= 7'd0;
      po_r         <= 8'd0;
      poc_r        <= 4'd0;
      n_r          <= 6'd0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      hb_r         <= hb_nxt;
      hbc_r        <= hbc_nxt;
      rsb_r        <= rsb_nxt;
      cl_r         <= cl_nxt;
      cbp_r        <= cbp_nxt;
      po_r         <= po_nxt;
      poc_r        <= poc_nxt;
      n_r          <= n_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pend_val_r <= pend_val_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    hb_nxt         = hb_r;
    hbc_nxt        = hbc_r;
    rsb_nxt        = rsb_r;
    cl_nxt         = cl_r;
    cbp_nxt        = cbp_r;
    po_nxt         = po_r;
    poc_nxt        = poc_r;
    n_nxt          = n_r;
    pend_valid_nxt = pend_valid_r;
    pend_val_nxt   = pend_val_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_data.first_of_glyph) begin
            rsb_nxt = 7'd0;
            cl_nxt  = 5'd0;
            cbp_nxt = 7'd0;
            po_nxt  = 8'd0;
            poc_nxt = 4'd0;
          end
          // bits still held from the previous byte are dropped
          hb_nxt    = in_data.source_byte;
          hbc_nxt   = PAGE_BITS;
          n_nxt     = 6'd0;
          state_nxt = ST_RUN;
        end
      end

      ST_RUN: begin
        if (out_free) begin
          hb_nxt  = it_hb;
          hbc_nxt = it_hbc;
          rsb_nxt = it_rsb;
          cl_nxt  = it_cl;
          cbp_nxt = it_cbp;
          po_nxt  = it_po;
          poc_nxt = it_poc;
          if (it_emit) begin
            // the page held back is not the last one: hand it over
            if (pend_valid_r) begin
              out_valid_nxt            = 1'b1;
              out_data_nxt.page_byte   = pend_val_r;
              out_data_nxt.last_of_run = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_val_nxt   = it_val;
            n_nxt          = n_r + 6'd1;
            if (n_r + 6'd1 == 6'(MAX_RESULTS)) begin
              state_nxt = ST_FLUSH;
            end
          end else if (it_break) begin
            state_nxt = pend_valid_r ? ST_FLUSH : ST_IDLE;
          end
        end
      end

      ST_FLUSH: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.page_byte   = pend_val_r;
          out_data_nxt.last_of_run = 1'b1;
          pend_valid_nxt           = 1'b0;
          state_nxt                = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // an accepted byte always starts a walk
  a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == ST_RUN))
    else $error("accepted transaction did not start a walk");

  // the flush state always has a page byte held back
  a_flush_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH) |-> pend_valid_r)
    else $error("flush without a held page byte");

  // flushing presents the last page byte and returns to idle
  a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH && out_free) |=>
      (state_r == ST_IDLE && out_valid_r && out_data_r.last_of_run))
    else $error("flush did not present the last page byte");

  // the partial page never fills up without being emitted
  a_partial_short: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (poc_r < PAGE_BITS))
    else $error("partial page count reached a full page");

  // no walk produces more than the result limit
  a_result_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && n_r != 6'd0) |-> (n_r < 6'(MAX_RESULTS)))
    else $error("result count beyond the limit");

endmodule
